// ===== design/fss_pkg.sv =====
// ---------------------------------------------------------------------------
// Fair-share scheduler package
// Task table entry layout, run-queue key type, and request, status and
// task state codes.
// ---------------------------------------------------------------------------
package fss_pkg;

	localparam int TimeW  = 48;
	localparam int OrderW = 32;

	// Request codes
	localparam logic [1:0] REQ_ACTIVATE = 2'd0;
	localparam logic [1:0] REQ_SCHEDULE = 2'd1;
	localparam logic [1:0] REQ_QUERY    = 2'd2;

	// Status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_NOOP  = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	// State requested for the outgoing task
	localparam logic [1:0] NS_RUNNABLE = 2'd0;
	localparam logic [1:0] NS_SLEEPING = 2'd1;
	localparam logic [1:0] NS_ZOMBIE   = 2'd2;

	// Task states as held in the table
	localparam logic [2:0] TS_UNUSED   = 3'd0;
	localparam logic [2:0] TS_RUNNABLE = 3'd1;
	localparam logic [2:0] TS_RUNNING  = 3'd2;
	localparam logic [2:0] TS_SLEEPING = 3'd3;
	localparam logic [2:0] TS_ZOMBIE   = 3'd4;

	typedef struct packed {
		logic [2:0]        state;
		logic [TimeW-1:0]  vruntime;
		logic [TimeW-1:0]  start;
		logic [OrderW-1:0] order;
	} task_entry_t;

	typedef struct packed {
		logic [TimeW-1:0]  vruntime;
		logic [OrderW-1:0] order;
	} queue_key_t;

	typedef struct packed {
		logic best_valid;
		logic second_valid;
	} scan_flags_t;

	// True when key a goes ahead of key b in the run queue.
	function automatic logic key_before(input queue_key_t a, input queue_key_t b);
		if (a.vruntime != b.vruntime) begin
			return a.vruntime < b.vruntime;
		end
		return a.order < b.order;
	endfunction

	function automatic logic [TimeW-1:0] time_max(input logic [TimeW-1:0] a,
			input logic [TimeW-1:0] b);
		return (a < b) ? b : a;
	endfunction

endpackage

// ===== design/fss_task_mem.sv =====
// ---------------------------------------------------------------------------
// Task table memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ---------------------------------------------------------------------------
module fss_task_mem #(
	parameter int Depth = 64,
	parameter int AddrW = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AddrW-1:0]    waddr,
	input  fss_pkg::task_entry_t wdata,
	input  logic                re,
	input  logic [AddrW-1:0]    raddr,
	output fss_pkg::task_entry_t rdata
);
	import fss_pkg::*;

	task_entry_t mem_q [Depth];
	task_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/fss_scan.sv =====
// ---------------------------------------------------------------------------
// Run-queue minimum scan
// Watches the table entries streaming out of the memory and keeps the least
// runnable task and the least of the rest.
// ---------------------------------------------------------------------------
module fss_scan #(
	parameter int IdxW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 init,
	input  logic                 load,
	input  logic [IdxW-1:0]      idx,
	input  fss_pkg::task_entry_t entry,
	output fss_pkg::scan_flags_t flags,
	output logic [IdxW-1:0]      best_idx,
	output fss_pkg::queue_key_t  best_key,
	output fss_pkg::queue_key_t  second_key
);
	import fss_pkg::*;

	logic        best_valid_q;
	logic        second_valid_q;
	logic [IdxW-1:0] best_idx_q;
	queue_key_t  best_key_q;
	queue_key_t  second_key_q;
	queue_key_t  key;
	logic        runnable;
	logic        ahead_of_best;
	logic        ahead_of_second;

	assign key.vruntime    = entry.vruntime;
	assign key.order       = entry.order;
	assign runnable        = (entry.state == TS_RUNNABLE);
	// A strict compare keeps the lower index on a full tie.
	assign ahead_of_best   = !best_valid_q || key_before(key, best_key_q);
	assign ahead_of_second = !second_valid_q || key_before(key, second_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q   <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (init) begin
			best_valid_q   <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (load && runnable) begin
			if (ahead_of_best) begin
				best_valid_q   <= 1'b1;
				second_valid_q <= best_valid_q;
			end else if (ahead_of_second) begin
				second_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!init && load && runnable) begin
			if (ahead_of_best) begin
				best_idx_q   <= idx;
				best_key_q   <= key;
				second_key_q <= best_key_q;
			end else if (ahead_of_second) begin
				second_key_q <= key;
			end
		end
	end

	assign flags.best_valid   = best_valid_q;
	assign flags.second_valid = second_valid_q;
	assign best_idx           = best_idx_q;
	assign best_key           = best_key_q;
	assign second_key         = second_key_q;

endmodule

// ===== design/fair_share_task_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// Fair-share task scheduler core
// Virtual-runtime run queue over a task table held in one memory, with one
// current task per CPU.
// ---------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Each
// request gives exactly one result beat: done is high for one cycle with
// status, next_task, next_is_idle and task_state valid alongside it. The
// receiver cannot stall, so results are simply presented and dropped.
// An activate or query of a valid task reads the task's table entry and
// answers from it; requests answered without a table access (out-of-range
// task or CPU, unknown code) are answered from the request decode. A
// schedule first charges the outgoing task (read, add, write back) when the
// CPU was not idle, then scans the table and picks; with halt_to_idle set
// the scan is skipped. The scan reads one table entry a cycle through the
// single memory read port, which sets the schedule time. The next request
// can be taken at the edge that takes the result beat. Only one request is
// in flight, so table reads and writes never overlap. After reset the block
// sweeps the task table clear, one entry a cycle, with busy high. The user
// writes halt_to_idle through cfg_we/cfg_wdata only while no request is in
// flight, which the block does not enforce; it applies from the next.
// ---------------------------------------------------------------------------
module fair_share_task_scheduler_core #(
	parameter int NUM_TASKS = 64,
	parameter int NUM_CPUS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [5:0]  task_id,
	input  logic [1:0]  cpu_id,
	input  logic [1:0]  exit_state,
	input  logic [47:0] now,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  next_task,
	output logic        next_is_idle,
	output logic [2:0]  task_state
);
	import fss_pkg::*;

	localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam logic [TW-1:0] LastIdx = TW'(NUM_TASKS - 1);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_ACT     = 10'b0000000100,
		S_QRY     = 10'b0000001000,
		S_CHG_RD  = 10'b0000010000,
		S_CHG_ADD = 10'b0000100000,
		S_CHG_WR  = 10'b0001000000,
		S_SCAN    = 10'b0010000000,
		S_DRAIN   = 10'b0100000000,
		S_PICK    = 10'b1000000000
	} fsm_t;

	fsm_t              state_q;
	logic              halt_q;
	logic [TW-1:0]     idx_q;
	logic [TW-1:0]     tid_q;
	logic [CW-1:0]     cpu_q;
	logic [1:0]        ns_q;
	logic [TimeW-1:0]  now_q;
	logic [TW-1:0]     chg_addr_q;
	task_entry_t       chg_ent_q;
	logic [TimeW-1:0]  delta_s1;
	logic [TimeW-1:0]  vr_s2;
	logic [OrderW-1:0] seq_q;
	logic [TimeW-1:0]  min_q;
	logic [TW-1:0]     cur_q  [NUM_CPUS];
	logic              idle_q [NUM_CPUS];
	logic              ld_s1;
	logic [TW-1:0]     idx_s1;

	logic              done_q;
	logic [1:0]        status_q;
	logic [5:0]        next_task_q;
	logic              next_is_idle_q;
	logic [2:0]        task_state_q;

	// Table memory ports
	logic              mem_we;
	logic [TW-1:0]     mem_waddr;
	task_entry_t       mem_wdata;
	logic              mem_re;
	logic [TW-1:0]     mem_raddr;
	task_entry_t       mem_rdata;

	// Scan unit
	logic              scan_init;
	scan_flags_t       scan_flags;
	logic [TW-1:0]     best_idx;
	queue_key_t        best_key;
	queue_key_t        second_key;

	// Request decode
	logic              tid_ok;
	logic              cpu_ok;
	logic [TW-1:0]     tid_addr;
	logic [CW-1:0]     cpu_sel;
	logic [TW-1:0]     cur_sel;
	logic              act_enqueue;
	logic [TimeW:0]    charge_sum;

	// Result assembly
	logic              resp_fire;
	logic [1:0]        resp_status;
	logic [5:0]        resp_next;
	logic              resp_idle;
	logic [2:0]        resp_state;

	assign tid_ok   = ({5'd0, task_id} < 11'(NUM_TASKS));
	assign cpu_ok   = ({3'd0, cpu_id} < 5'(NUM_CPUS));
	assign tid_addr = TW'(task_id);
	assign cpu_sel  = CW'(cpu_id);
	assign cur_sel  = cpu_ok ? cur_q[cpu_sel] : '0;

	assign act_enqueue = (mem_rdata.state == TS_SLEEPING) || (mem_rdata.state == TS_UNUSED);
	assign charge_sum  = {1'b0, chg_ent_q.vruntime} + {1'b0, delta_s1};

	assign scan_init = (state_q == S_IDLE) || (state_q == S_CHG_WR);

	fss_task_mem #(
		.Depth (NUM_TASKS),
		.AddrW (TW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fss_scan #(
		.IdxW (TW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.init       (scan_init),
		.load       (ld_s1),
		.idx        (idx_s1),
		.entry      (mem_rdata),
		.flags      (scan_flags),
		.best_idx   (best_idx),
		.best_key   (best_key),
		.second_key (second_key)
	);

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = idx_q;
		resp_fire   = 1'b0;
		resp_status = STATUS_DONE;
		resp_next   = '0;
		resp_idle   = 1'b0;
		resp_state  = TS_UNUSED;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
			end
			S_IDLE: begin
				mem_re    = start;
				mem_raddr = (req_type == REQ_SCHEDULE) ? cur_sel : tid_addr;
				if (start) begin
					case (req_type)
						REQ_ACTIVATE: begin
							if (!tid_ok) begin
								resp_fire   = 1'b1;
								resp_status = STATUS_ERROR;
							end
						end
						REQ_SCHEDULE: begin
							if (!cpu_ok) begin
								resp_fire = 1'b1;
								resp_idle = 1'b1;
							end
						end
						REQ_QUERY: begin
							resp_fire = !tid_ok;
						end
						default: begin
							resp_fire = 1'b1;
						end
					endcase
				end
			end
			S_ACT: begin
				resp_fire = 1'b1;
				if (act_enqueue) begin
					mem_we                 = 1'b1;
					mem_waddr              = tid_q;
					mem_wdata              = mem_rdata;
					mem_wdata.state        = TS_RUNNABLE;
					mem_wdata.vruntime     = time_max(mem_rdata.vruntime, min_q);
					mem_wdata.order        = seq_q;
				end else if (mem_rdata.state == TS_ZOMBIE) begin
					resp_status = STATUS_ERROR;
				end else begin
					resp_status = STATUS_NOOP;
				end
			end
			S_QRY: begin
				resp_fire  = 1'b1;
				resp_state = mem_rdata.state;
			end
			S_CHG_WR: begin
				mem_we    = 1'b1;
				mem_waddr = chg_addr_q;
				mem_wdata = chg_ent_q;
				case (ns_q)
					NS_RUNNABLE: begin
						mem_wdata.state    = TS_RUNNABLE;
						mem_wdata.vruntime = time_max(vr_s2, min_q);
						mem_wdata.order    = seq_q;
					end
					NS_ZOMBIE: begin
						mem_wdata.state    = TS_ZOMBIE;
						mem_wdata.vruntime = vr_s2;
					end
					default: begin
						mem_wdata.state    = TS_SLEEPING;
						mem_wdata.vruntime = vr_s2;
					end
				endcase
			end
			S_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q;
			end
			S_PICK: begin
				resp_fire = 1'b1;
				if (scan_flags.best_valid) begin
					mem_we             = 1'b1;
					mem_waddr          = best_idx;
					mem_wdata.state    = TS_RUNNING;
					mem_wdata.vruntime = best_key.vruntime;
					mem_wdata.start    = now_q;
					mem_wdata.order    = best_key.order;
					resp_next          = 6'(best_idx);
				end else begin
					resp_idle = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q <= 1'b0;
		end else if (cfg_we) begin
			halt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			idx_q          <= '0;
			seq_q          <= '0;
			min_q          <= '0;
			ld_s1          <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= '0;
			next_task_q    <= '0;
			next_is_idle_q <= 1'b0;
			task_state_q   <= '0;
			for (int c = 0; c < NUM_CPUS; c++) begin
				cur_q[c]  <= '0;
				idle_q[c] <= 1'b1;
			end
		end else begin
			ld_s1  <= (state_q == S_SCAN);
			done_q <= resp_fire;
			if (resp_fire) begin
				status_q       <= resp_status;
				next_task_q    <= resp_next;
				next_is_idle_q <= resp_idle;
				task_state_q   <= resp_state;
			end
			case (state_q)
				S_CLEAR: begin
					if (idx_q == LastIdx) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start && !resp_fire) begin
						case (req_type)
							REQ_ACTIVATE: begin
								state_q <= S_ACT;
							end
							REQ_QUERY: begin
								state_q <= S_QRY;
							end
							default: begin
								// A schedule on a valid CPU
								if (!idle_q[cpu_sel]) begin
									state_q <= S_CHG_RD;
								end else if (halt_q) begin
									state_q <= S_PICK;
								end else begin
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_ACT: begin
					if (act_enqueue) begin
						seq_q <= seq_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_QRY: begin
					state_q <= S_IDLE;
				end
				S_CHG_RD: begin
					state_q <= S_CHG_ADD;
				end
				S_CHG_ADD: begin
					state_q <= S_CHG_WR;
				end
				S_CHG_WR: begin
					if (ns_q == NS_RUNNABLE) begin
						seq_q <= seq_q + 1'b1;
					end
					state_q <= halt_q ? S_PICK : S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == LastIdx) begin
						idx_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (scan_flags.best_valid) begin
						if (scan_flags.second_valid) begin
							min_q <= second_key.vruntime;
						end
						cur_q[cpu_q]  <= best_idx;
						idle_q[cpu_q] <= 1'b0;
					end else begin
						idle_q[cpu_q] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request fields and the charge datapath need no reset.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (state_q == S_IDLE && start) begin
			tid_q      <= tid_addr;
			cpu_q      <= cpu_sel;
			ns_q       <= exit_state;
			now_q      <= now;
			chg_addr_q <= cur_sel;
		end
		if (state_q == S_CHG_RD) begin
			chg_ent_q <= mem_rdata;
			// Elapsed time wraps with the timestamp.
			delta_s1  <= now_q - mem_rdata.start;
		end
		if (state_q == S_CHG_ADD) begin
			vr_s2 <= charge_sum[TimeW] ? {TimeW{1'b1}} : charge_sum[TimeW-1:0];
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign next_task    = next_task_q;
	assign next_is_idle = next_is_idle_q;
	assign task_state   = task_state_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fair-share task scheduler core testbench
// Sends activate, schedule, query and undefined requests over the start/busy
// handshake and keeps a behavioural copy of the run queue. Every done beat is
// checked field by field against the oldest predicted outcome.
// ----------------------------------------------------------------------------
module tb;
	import fss_pkg::*;

	localparam int NTASK = 64;
	localparam int NCPU  = 4;
	// The slowest correct run is about 650 requests, each spending its time in
	// the core plus a sender gap, after the table clear; the limit allows
	// several times the length of that run.
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 80;

	localparam logic [1:0]  REQ_UNDEFINED = 2'd3;
	localparam logic [1:0]  NS_UNDEFINED  = 2'd3;
	localparam logic [47:0] TIME_MAX      = '1;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] next_task;
		logic       next_is_idle;
		logic [2:0] task_state;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = '0;
	logic [5:0]  task_id = '0;
	logic [1:0]  cpu_id = '0;
	logic [1:0]  exit_state = '0;
	logic [47:0] now = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  next_task;
	logic        next_is_idle;
	logic [2:0]  task_state;

	// Scheduler state as the testbench expects it to be
	bit [2:0]  m_state [NTASK];
	bit [47:0] m_vruntime [NTASK];
	bit [47:0] m_started [NTASK];
	bit [31:0] m_order [NTASK];
	bit [31:0] m_next_order;
	bit [47:0] m_floor;
	bit [5:0]  m_cpu_task [NCPU];
	bit        m_cpu_idle [NCPU] = '{default: 1'b1};
	bit        m_halt;

	outcome_t    pending_outcomes [$];
	int          mismatches;
	int          cycle_count;
	int          items_sent;
	int          results_seen;
	int          tasks_picked;
	int          idle_picks;
	int          saturations;
	bit          gaps_enabled = 1'b1;
	int          burst_left;
	logic [47:0] sim_now;

	fair_share_task_scheduler_core #(
		.NUM_TASKS(NTASK),
		.NUM_CPUS (NCPU)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.task_id     (task_id),
		.cpu_id      (cpu_id),
		.exit_state  (exit_state),
		.now         (now),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.status      (status),
		.next_task   (next_task),
		.next_is_idle(next_is_idle),
		.task_state  (task_state)
	);

	always #1 clk = ~clk;

	function automatic int least_runnable(input int skip);
		int best;
		best = -1;
		for (int t = 0; t < NTASK; t++) begin
			if (m_state[t] == TS_RUNNABLE && t != skip) begin
				if (best < 0 || m_vruntime[t] < m_vruntime[best] ||
						(m_vruntime[t] == m_vruntime[best] && m_order[t] < m_order[best])) begin
					best = t;
				end
			end
		end
		return best;
	endfunction

	function automatic void requeue(input int t);
		m_state[t] = TS_RUNNABLE;
		if (m_vruntime[t] < m_floor) begin
			m_vruntime[t] = m_floor;
		end
		m_order[t] = m_next_order;
		m_next_order = m_next_order + 1;
	endfunction

	function automatic outcome_t predict_outcome(input logic [1:0] req, input logic [5:0] tid,
			input logic [1:0] cpu, input logic [1:0] ns, input logic [47:0] t_now);
		outcome_t  o;
		int        cur;
		int        pick;
		int        rest;
		bit [48:0] charged;
		o = '0;
		case (req)
			REQ_ACTIVATE: begin
				if (m_state[tid] == TS_RUNNING || m_state[tid] == TS_RUNNABLE) begin
					o.status = STATUS_NOOP;
				end else if (m_state[tid] == TS_ZOMBIE) begin
					o.status = STATUS_ERROR;
				end else begin
					requeue(tid);
				end
			end
			REQ_SCHEDULE: begin
				if (!m_cpu_idle[cpu]) begin
					cur = m_cpu_task[cpu];
					// Elapsed time wraps at 48 bits; the sum saturates instead.
					charged = {1'b0, m_vruntime[cur]} + {1'b0, t_now - m_started[cur]};
					if (charged[48]) begin
						saturations++;
					end
					m_vruntime[cur] = charged[48] ? TIME_MAX : charged[47:0];
					if (ns == NS_RUNNABLE) begin
						requeue(cur);
					end else if (ns == NS_ZOMBIE) begin
						m_state[cur] = TS_ZOMBIE;
					end else begin
						m_state[cur] = TS_SLEEPING;
					end
				end
				pick = m_halt ? -1 : least_runnable(-1);
				if (pick < 0) begin
					m_cpu_idle[cpu] = 1'b1;
					o.next_is_idle = 1'b1;
					idle_picks++;
				end else begin
					rest = least_runnable(pick);
					if (rest >= 0) begin
						m_floor = m_vruntime[rest];
					end
					m_state[pick] = TS_RUNNING;
					m_started[pick] = t_now;
					m_cpu_task[cpu] = 6'(pick);
					m_cpu_idle[cpu] = 1'b0;
					o.next_task = 6'(pick);
					tasks_picked++;
				end
			end
			REQ_QUERY: begin
				o.task_state = m_state[tid];
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Between bursts the sender drops start for a short or a long gap, so that
	// gaps land on every stage of a schedule scan.
	task automatic pace_sender();
		if (!gaps_enabled) begin
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		start <= 1'b0;
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
			@(posedge clk);
		burst_left = $urandom_range(0, 15);
	endtask

	task automatic issue_request(input logic [1:0] req, input logic [5:0] tid,
			input logic [1:0] cpu, input logic [1:0] ns, input logic [47:0] t_now);
		start      <= 1'b1;
		req_type   <= req;
		task_id    <= tid;
		cpu_id     <= cpu;
		exit_state <= ns;
		now        <= t_now;
		do @(posedge clk); while (busy !== 1'b0);
		pending_outcomes.push_back(predict_outcome(req, tid, cpu, ns, t_now));
		items_sent++;
		pace_sender();
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending_outcomes.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_halt_to_idle(input bit value);
		wait_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_halt = value;
	endtask

	task automatic test_empty_table();
		issue_request(REQ_QUERY, 6'd0, 2'd0, NS_RUNNABLE, 48'd0);
		issue_request(REQ_QUERY, 6'd63, 2'd3, NS_UNDEFINED, TIME_MAX);
		issue_request(REQ_UNDEFINED, 6'd63, 2'd3, NS_UNDEFINED, TIME_MAX);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd3, NS_UNDEFINED, 48'd0);
	endtask

	task automatic test_run_queue_order();
		issue_request(REQ_ACTIVATE, 6'd0, 2'd0, NS_RUNNABLE, 48'd0);
		issue_request(REQ_ACTIVATE, 6'd63, 2'd0, NS_RUNNABLE, 48'd0);
		issue_request(REQ_ACTIVATE, 6'd0, 2'd0, NS_RUNNABLE, 48'd0);
		// Equal vruntimes: the task queued first must win.
		issue_request(REQ_SCHEDULE, 6'd0, 2'd0, NS_RUNNABLE, 48'd0);
		issue_request(REQ_ACTIVATE, 6'd0, 2'd0, NS_RUNNABLE, 48'd0);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd1, NS_RUNNABLE, 48'd5);
		// Full-range charge, then a timestamp that wraps and a charge that saturates.
		issue_request(REQ_SCHEDULE, 6'd0, 2'd0, NS_RUNNABLE, TIME_MAX);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd0, NS_RUNNABLE, 48'd10);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd1, NS_ZOMBIE, 48'd20);
		issue_request(REQ_ACTIVATE, 6'd63, 2'd1, NS_RUNNABLE, 48'd20);
		issue_request(REQ_QUERY, 6'd63, 2'd1, NS_RUNNABLE, 48'd20);
		// An undefined outgoing state is taken as sleeping.
		issue_request(REQ_SCHEDULE, 6'd0, 2'd0, NS_UNDEFINED, 48'd30);
		issue_request(REQ_QUERY, 6'd0, 2'd0, NS_RUNNABLE, 48'd30);
		issue_request(REQ_ACTIVATE, 6'd0, 2'd0, NS_RUNNABLE, 48'd30);
		issue_request(REQ_ACTIVATE, 6'd5, 2'd0, NS_RUNNABLE, 48'd30);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd2, NS_RUNNABLE, 48'd40);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd2, NS_SLEEPING, 48'd40);
		issue_request(REQ_ACTIVATE, 6'd5, 2'd2, NS_RUNNABLE, 48'd40);
		issue_request(REQ_QUERY, 6'd5, 2'd2, NS_RUNNABLE, 48'd40);
	endtask

	task automatic test_halt_to_idle();
		write_halt_to_idle(1'b1);
		issue_request(REQ_ACTIVATE, 6'd9, 2'd0, NS_RUNNABLE, 48'd50);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd3, NS_RUNNABLE, 48'd50);
		// The outgoing task is still charged and queued again.
		issue_request(REQ_SCHEDULE, 6'd0, 2'd2, NS_RUNNABLE, 48'd60);
		issue_request(REQ_QUERY, 6'd0, 2'd2, NS_RUNNABLE, 48'd60);
		write_halt_to_idle(1'b0);
		issue_request(REQ_SCHEDULE, 6'd0, 2'd2, NS_RUNNABLE, 48'd70);
	endtask

	// Mostly well-formed traffic on a group of pool tasks from first_task, so that tasks cycle
	// through the queue many times; some requests reach anywhere in the table.
	task automatic test_random_workload(input int count, input int first_task, input int pool,
			input bit with_gaps);
		int         roll;
		logic [1:0] req;
		logic [5:0] tid;
		logic [1:0] ns;
		gaps_enabled = with_gaps;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			req = (roll < 35) ? REQ_ACTIVATE : (roll < 75) ? REQ_SCHEDULE :
				(roll < 95) ? REQ_QUERY : REQ_UNDEFINED;
			tid = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) :
				6'(first_task + $urandom_range(0, pool - 1));
			roll = $urandom_range(0, 99);
			ns = (roll < 60) ? NS_RUNNABLE : (roll < 85) ? NS_SLEEPING :
				(roll < 90) ? NS_ZOMBIE : NS_UNDEFINED;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				sim_now = {16'($urandom), $urandom};
			end else if (roll < 6) begin
				sim_now = TIME_MAX - $urandom_range(0, 50);
			end else begin
				sim_now = sim_now + $urandom_range(0, 2000);
			end
			issue_request(req, tid, 2'($urandom_range(0, 3)), ns, sim_now);
		end
	endtask

	always @(posedge clk) begin : result_checker
		outcome_t want;
		outcome_t got;
		if (arst_n && done === 1'b1) begin
			got = {status, next_task, next_is_idle, task_state};
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("cycle %0d: result beat with no request outstanding", cycle_count);
				end
			end else begin
				want = pending_outcomes.pop_front();
				if (got.status !== want.status || got.next_task !== want.next_task ||
						got.next_is_idle !== want.next_is_idle ||
						got.task_state !== want.task_state) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("cycle %0d: expected status %0d next_task %0d idle %0d state %0d",
							cycle_count, want.status, want.next_task, want.next_is_idle,
							want.task_state);
						$display("          got      status %0d next_task %0d idle %0d state %0d",
							got.status, got.next_task, got.next_is_idle, got.task_state);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d results outstanding", cycle_count,
				pending_outcomes.size());
			$display("FAIL fair_share_task_scheduler_core");
			$finish;
		end
	end

	initial begin
		sim_now = 48'd100;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_run_queue_order();
		test_halt_to_idle();
		test_random_workload(250, 0, 16, 1'b1);
		write_halt_to_idle(1'b1);
		test_random_workload(50, 16, 16, 1'b1);
		write_halt_to_idle(1'b0);
		test_random_workload(220, 32, 24, 1'b0);
		test_random_workload(60, 0, 64, 1'b1);
		wait_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += pending_outcomes.size();
		$display("%0d requests sent, %0d result beats checked, %0d mismatches", items_sent,
			results_seen, mismatches);
		$display("schedules: %0d picked a task, %0d went idle; %0d saturated charges",
			tasks_picked, idle_picks, saturations);
		if (mismatches == 0) begin
			$display("PASS fair_share_task_scheduler_core");
		end else begin
			$display("FAIL fair_share_task_scheduler_core");
		end
		$finish;
	end

endmodule
